// ----- hw/rtl/pvi_pkg.sv -----
// Shared constants, types and fixed-point helpers for the PID increment block.
`timescale 1ns / 1ps
package pvi_pkg;

   // Fixed-point format and pipeline geometry
   localparam int FRAC_BITS = 16;
   localparam int Q_W       = 32;
   localparam int NUM_W     = Q_W + FRAC_BITS;
   localparam int DIV_STEPS = Q_W - 1;
   localparam int DIV_LAT   = DIV_STEPS + 2;
   localparam int POST_LAT  = 4;
   localparam int PIPE_LAT  = DIV_LAT + POST_LAT;

   localparam logic signed [Q_W-1:0] Q_MAX   = 32'sh7fffffff;
   localparam logic signed [Q_W-1:0] Q_MIN   = 32'sh80000000;
   localparam logic signed [Q_W-1:0] Q_ONE   = 32'(64'd1 << FRAC_BITS);
   localparam logic signed [Q_W-1:0] Q_THREE = 32'(64'd3 << FRAC_BITS);
   localparam logic signed [Q_W-1:0] Q_TEN   = 32'(64'd10 << FRAC_BITS);
   localparam logic signed [Q_W-1:0] Q_HUNDRED = 32'(64'd100 << FRAC_BITS);

   // Divide by 100 as multiply by ceil(2^38 / 100) and shift; exact below 2^32
   localparam logic [Q_W-1:0] PCT_RECIP = 32'd2748779070;
   localparam int             PCT_SHIFT = 38;

   // Register indexes
   localparam logic [2:0] CSR_PROP_BAND     = 3'd0;
   localparam logic [2:0] CSR_INTEGRAL_TIME = 3'd1;
   localparam logic [2:0] CSR_DERIV_TIME    = 3'd2;
   localparam logic [2:0] CSR_OUT_SPAN      = 3'd3;
   localparam logic [2:0] CSR_IN_SPAN       = 3'd4;
   localparam logic [2:0] CSR_ALGORITHM     = 3'd5;

   // Algorithm codes
   localparam logic [2:0] ALG_AUTO     = 3'd0;
   localparam logic [2:0] ALG_IPD      = 3'd1;
   localparam logic [2:0] ALG_PID      = 3'd2;
   localparam logic [2:0] ALG_BASIC    = 3'd3;
   localparam logic [2:0] ALG_AUTO_ALT = 3'd4;

   // Request fields carried alongside the dividers
   typedef struct packed {
      logic signed [Q_W-1:0] error;
      logic signed [Q_W-1:0] error_delta;
      logic signed [Q_W-1:0] pv_delta;
      logic signed [Q_W-1:0] pv_diff;
      logic [Q_W-2:0]        step_time;
      logic                  cascade_mode;
      logic                  early_step;
   } side_type;

   // Divider results
   typedef struct packed {
      logic signed [Q_W-1:0] ks;
      logic signed [Q_W-1:0] kp;
      logic signed [Q_W-1:0] v;
      logic signed [Q_W-1:0] q_int;
      logic signed [Q_W-1:0] q_der;
      logic signed [Q_W-1:0] rate;
   } quo_type;

   // Static configuration seen by the back end
   typedef struct packed {
      logic [Q_W-2:0] deriv_time;
      logic [2:0]     algorithm;
      logic           bypass;
      logic           no_int;
   } cfg_type;

   function automatic logic signed [Q_W-1:0] q_sat33(input logic signed [Q_W:0] x);
      logic signed [Q_W-1:0] r;
      if (x > (Q_W+1)'(Q_MAX)) r = Q_MAX;
      else if (x < (Q_W+1)'(Q_MIN)) r = Q_MIN;
      else r = x[Q_W-1:0];
      return r;
   endfunction

   function automatic logic signed [Q_W-1:0] q_add(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
      logic signed [Q_W:0] s;
      s = (Q_W+1)'(a) + (Q_W+1)'(b);
      return q_sat33(s);
   endfunction

   function automatic logic signed [Q_W-1:0] q_sub(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
      logic signed [Q_W:0] s;
      s = (Q_W+1)'(a) - (Q_W+1)'(b);
      return q_sat33(s);
   endfunction

   // Product scaled down by floor, then saturated
   function automatic logic signed [Q_W-1:0] q_mul(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
      logic signed [2*Q_W-1:0] p;
      logic signed [2*Q_W-1:0] s;
      logic signed [Q_W-1:0]   r;
      p = (2*Q_W)'(a) * (2*Q_W)'(b);
      s = p >>> FRAC_BITS;
      if (s > (2*Q_W)'(Q_MAX)) r = Q_MAX;
      else if (s < (2*Q_W)'(Q_MIN)) r = Q_MIN;
      else r = s[Q_W-1:0];
      return r;
   endfunction

endpackage

// ----- hw/rtl/pvi_div.sv -----
// Pipelined fixed-point divider, one quotient bit per stage, saturating result.
`timescale 1ns / 1ps
module pvi_div (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [pvi_pkg::Q_W-1:0] num,
   input  logic signed [pvi_pkg::Q_W-1:0] den,
   output logic signed [pvi_pkg::Q_W-1:0] quo
);
   import pvi_pkg::*;

   logic [NUM_W-1:0]     rem_ff [0:DIV_STEPS-1];
   logic [Q_W-1:0]       den_ff [0:DIV_STEPS-1];
   logic [DIV_STEPS-1:0] q_ff   [0:DIV_STEPS];
   logic                 neg_ff [0:DIV_STEPS];
   logic                 ovf_ff [0:DIV_STEPS];
   logic signed [Q_W-1:0] quo_ff;

   logic [Q_W-1:0]   num_mag;
   logic [Q_W-1:0]   den_mag;
   logic [NUM_W-1:0] num_sh;
   logic             ovf_in;
   logic signed [Q_W-1:0] quo_in;

   // Magnitudes and overflow test: quotient reaches 2^31 when num*2^F >= den*2^31
   always_comb begin
      num_mag = num[Q_W-1] ? Q_W'(-num) : Q_W'(num);
      den_mag = den[Q_W-1] ? Q_W'(-den) : Q_W'(den);
      num_sh  = {num_mag, FRAC_BITS'(0)};
      ovf_in  = {DIV_STEPS'(0), num_sh[NUM_W-1:DIV_STEPS]} >=
                {(NUM_W-Q_W)'(0), den_mag};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_sh;
         den_ff[0] <= den_mag;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[Q_W-1] ^ den[Q_W-1];
         ovf_ff[0] <= ovf_in;
      end
   end

   // Restoring steps, most significant quotient bit first
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int BIT = DIV_STEPS - 1 - k;
      logic [NUM_W-1:0] den_ext;
      logic             fits;
      logic [NUM_W-1:0] rem_in;

      always_comb begin
         den_ext = {(NUM_W-Q_W)'(0), den_ff[k]};
         fits    = (rem_ff[k] >> BIT) >= den_ext;
         rem_in  = fits ? rem_ff[k] - (den_ext << BIT) : rem_ff[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k+1]   <= q_ff[k] | (fits ? (DIV_STEPS'(1) << BIT) : DIV_STEPS'(0));
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end

      if (k < DIV_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= rem_in;
               den_ff[k+1] <= den_ff[k];
            end
         end
      end
   end

   // Sign and saturation
   always_comb begin
      if (ovf_ff[DIV_STEPS]) quo_in = neg_ff[DIV_STEPS] ? Q_MIN : Q_MAX;
      else if (neg_ff[DIV_STEPS]) quo_in = -Q_W'({1'b0, q_ff[DIV_STEPS]});
      else quo_in = Q_W'({1'b0, q_ff[DIV_STEPS]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

// ----- hw/rtl/pvi_post.sv -----
// Back end: gain products, algorithm sums, final gain and PI-D clamp.
`timescale 1ns / 1ps
module pvi_post (
   input  logic                           clock,
   input  logic                           en,
   input  pvi_pkg::cfg_type               cfg,
   input  pvi_pkg::quo_type               quo,
   input  pvi_pkg::side_type              side,
   output logic signed [pvi_pkg::Q_W-1:0] output_delta
);
   import pvi_pkg::*;

   localparam logic [1:0] KIND_ZERO   = 2'd0;
   localparam logic [1:0] KIND_MUL    = 2'd1;
   localparam logic [1:0] KIND_CLAMP  = 2'd2;
   localparam logic [1:0] KIND_BYPASS = 2'd3;

   // Stage 1: products
   logic signed [Q_W-1:0] ti_ff, g_ff, e_ff, dr_ff, ks1_ff, v1_ff, den1_ff, dpv1_ff;
   logic                  rate_ok_ff, cas1_ff, early1_ff;
   logic signed [Q_W-1:0] ti_src;

   always_comb begin
      ti_src = cfg.no_int ? Q_W'({1'b0, side.step_time}) : quo.q_int;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ti_ff      <= q_mul(ti_src, side.error);
         g_ff       <= q_mul(quo.kp, quo.ks);
         e_ff       <= q_mul(quo.q_der, side.pv_diff);
         dr_ff      <= q_mul(Q_W'({1'b0, cfg.deriv_time}), quo.rate);
         rate_ok_ff <= (quo.rate < Q_THREE) && (quo.rate > -Q_THREE);
         ks1_ff     <= quo.ks;
         v1_ff      <= quo.v;
         den1_ff    <= side.error_delta;
         dpv1_ff    <= side.pv_delta;
         cas1_ff    <= side.cascade_mode;
         early1_ff  <= side.early_step;
      end
   end

   // Stage 2: algorithm selection and saturating sums
   logic [2:0]            alg;
   logic signed [Q_W-1:0] part;
   logic signed [Q_W-1:0] sum_in, sum_ff, g2_ff, v2_ff, byp_ff;
   logic [1:0]            kind_in, kind_ff;

   always_comb begin
      alg = cfg.algorithm;
      if (alg == ALG_AUTO || alg == ALG_AUTO_ALT) alg = cas1_ff ? ALG_PID : ALG_IPD;
      part    = q_add(dpv1_ff, ti_ff);
      sum_in  = '0;
      kind_in = KIND_ZERO;
      case (alg)
         ALG_BASIC: begin
            kind_in = KIND_MUL;
            sum_in  = rate_ok_ff ? q_add(q_add(den1_ff, ti_ff), dr_ff) : part;
         end
         ALG_IPD: begin
            kind_in = KIND_MUL;
            sum_in  = early1_ff ? part : q_add(part, e_ff);
         end
         ALG_PID: begin
            kind_in = KIND_CLAMP;
            sum_in  = q_add(q_add(den1_ff, ti_ff), e_ff);
         end
         default: begin
            kind_in = KIND_ZERO;
         end
      endcase
      if (cfg.bypass) kind_in = KIND_BYPASS;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff  <= sum_in;
         kind_ff <= kind_in;
         g2_ff   <= g_ff;
         v2_ff   <= v1_ff;
         byp_ff  <= q_mul(ks1_ff, ti_ff);
      end
   end

   // Stage 3: final gain
   logic signed [Q_W-1:0] prod_in, prod_ff, v3_ff;
   logic                  clamp_ff;

   always_comb begin
      case (kind_ff)
         KIND_BYPASS: prod_in = byp_ff;
         KIND_MUL:    prod_in = q_mul(g2_ff, sum_ff);
         KIND_CLAMP:  prod_in = q_mul(g2_ff, sum_ff);
         default:     prod_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         v3_ff    <= v2_ff;
         clamp_ff <= (kind_ff == KIND_CLAMP);
      end
   end

   // Stage 4: in PID mode without bypass, clamp to one percent of the output span
   logic signed [Q_W:0]   d_ext, v_ext;
   logic signed [Q_W-1:0] out_in, out_ff;

   always_comb begin
      d_ext  = (Q_W+1)'(prod_ff);
      v_ext  = (Q_W+1)'(v3_ff);
      out_in = prod_ff;
      if (clamp_ff) begin
         if (d_ext > 0 && d_ext > v_ext) out_in = v3_ff;
         else if (d_ext < 0 && d_ext < -v_ext) out_in = Q_W'(-v_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign output_delta = out_ff;

endmodule

// ----- hw/rtl/pid_velocity_increment.sv -----
// Request to response: 33-stage divider pipeline plus 4 back-end stages.
// Throughput: one request per cycle unless stalled; each divider stage retires one quotient bit.
// A held response stalls the whole pipeline in place; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits and restores register defaults.
// Top level: velocity-form PID increment with register port and request/response channels.
`timescale 1ns / 1ps
module pid_velocity_increment (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [pvi_pkg::Q_W-1:0] req_error,
   input  logic signed [pvi_pkg::Q_W-1:0] req_error_delta,
   input  logic signed [pvi_pkg::Q_W-1:0] req_prev_error_delta,
   input  logic signed [pvi_pkg::Q_W-1:0] req_pv_delta,
   input  logic signed [pvi_pkg::Q_W-1:0] req_prev_pv_delta,
   input  logic                           req_cascade_mode,
   input  logic                           req_early_step,
   input  logic [pvi_pkg::Q_W-2:0]        req_step_time,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [pvi_pkg::Q_W-1:0] rsp_output_delta,
   input  logic                           csr_write,
   input  logic [2:0]                     csr_index,
   input  logic [pvi_pkg::Q_W-1:0]        csr_data
);
   import pvi_pkg::*;

   // Configuration registers
   logic [Q_W-2:0]        prop_band_ff, integral_time_ff, deriv_time_ff, in_span_ff;
   logic signed [Q_W-1:0] out_span_ff;
   logic [2:0]            algorithm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_band_ff     <= Q_HUNDRED[Q_W-2:0];
         integral_time_ff <= Q_TEN[Q_W-2:0];
         deriv_time_ff    <= '0;
         out_span_ff      <= Q_HUNDRED;
         in_span_ff       <= Q_HUNDRED[Q_W-2:0];
         algorithm_ff     <= ALG_AUTO;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PROP_BAND:     prop_band_ff     <= csr_data[Q_W-2:0];
            CSR_INTEGRAL_TIME: integral_time_ff <= csr_data[Q_W-2:0];
            CSR_DERIV_TIME:    deriv_time_ff    <= csr_data[Q_W-2:0];
            CSR_OUT_SPAN:      out_span_ff      <= csr_data;
            CSR_IN_SPAN:       in_span_ff       <= csr_data[Q_W-2:0];
            CSR_ALGORITHM:     algorithm_ff     <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline advance and valid chain
   logic en;
   logic vld_ff [0:PIPE_LAT-1];

   assign en        = !vld_ff[PIPE_LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < PIPE_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // Zero step time and zero input span count as one LSB
   logic [Q_W-2:0] dt_eff, in_span_eff;
   side_type       side_in;

   always_comb begin
      dt_eff      = (req_step_time == '0) ? (Q_W-1)'(1) : req_step_time;
      in_span_eff = (in_span_ff == '0) ? (Q_W-1)'(1) : in_span_ff;
      side_in.error        = req_error;
      side_in.error_delta  = req_error_delta;
      side_in.pv_delta     = req_pv_delta;
      side_in.pv_diff      = q_sub(req_pv_delta, req_prev_pv_delta);
      side_in.step_time    = dt_eff;
      side_in.cascade_mode = req_cascade_mode;
      side_in.early_step   = req_early_step;
   end

   // Request fields delayed to line up with the quotients
   side_type side_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < DIV_LAT; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // Divider array
   quo_type quo;

   pvi_div u_div_ks (
      .clock(clock), .en(en), .num(out_span_ff),
      .den(Q_W'({1'b0, in_span_eff})), .quo(quo.ks)
   );
   pvi_div u_div_kp (
      .clock(clock), .en(en), .num(Q_HUNDRED),
      .den(Q_W'({1'b0, prop_band_ff})), .quo(quo.kp)
   );
   pvi_div u_div_int (
      .clock(clock), .en(en), .num(Q_W'({1'b0, dt_eff})),
      .den(Q_W'({1'b0, integral_time_ff})), .quo(quo.q_int)
   );
   pvi_div u_div_der (
      .clock(clock), .en(en), .num(Q_W'({1'b0, deriv_time_ff})),
      .den(Q_W'({1'b0, dt_eff})), .quo(quo.q_der)
   );
   pvi_div u_div_rate (
      .clock(clock), .en(en), .num(q_sub(req_error_delta, req_prev_error_delta)),
      .den(Q_W'({1'b0, dt_eff})), .quo(quo.rate)
   );

   // One percent of the output span, truncated toward zero, by reciprocal multiply
   logic [Q_W-1:0]        ospan_mag;
   logic [2*Q_W-1:0]      pct_prod;
   logic signed [Q_W-1:0] pct_in, pct_ff;

   always_comb begin
      ospan_mag = out_span_ff[Q_W-1] ? Q_W'(-out_span_ff) : Q_W'(out_span_ff);
      pct_prod  = (2*Q_W)'(ospan_mag) * (2*Q_W)'(PCT_RECIP);
      pct_in    = out_span_ff[Q_W-1] ? -Q_W'(pct_prod >> PCT_SHIFT)
                                     : Q_W'(pct_prod >> PCT_SHIFT);
   end

   always_ff @(posedge clock) begin
      pct_ff <= pct_in;
   end

   assign quo.v = pct_ff;

   // Back end
   cfg_type cfg;

   always_comb begin
      cfg.deriv_time = deriv_time_ff;
      cfg.algorithm  = algorithm_ff;
      cfg.bypass     = (prop_band_ff == '0);
      cfg.no_int     = (integral_time_ff == '0);
   end

   pvi_post u_post (
      .clock(clock), .en(en), .cfg(cfg), .quo(quo), .side(side_ff[DIV_LAT-1]),
      .output_delta(rsp_output_delta)
   );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the velocity-form PID increment block.
`timescale 1ns / 1ps
module tb_top;
   import pvi_pkg::*;

   localparam int LATENCY  = 37;
   localparam int WD_LIMIT = 20000;
   localparam int N_RANDOM = 1400;
   localparam logic signed [63:0] L_MAX = 64'sd2147483647;
   localparam logic signed [63:0] L_MIN = -64'sd2147483648;
   localparam logic signed [63:0] L_ONE = 64'sd65536;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_error = '0, req_error_delta = '0, req_prev_error_delta = '0;
   logic signed [31:0] req_pv_delta = '0, req_prev_pv_delta = '0;
   logic req_cascade_mode = 1'b0, req_early_step = 1'b0;
   logic [30:0] req_step_time = 31'd1;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_output_delta;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   pid_velocity_increment dut (.*);

   always #5 clock = ~clock;

   // One request as the table and random part see it
   typedef struct {
      logic signed [31:0] err, derr, derr1, dpv, dpv1;
      logic cas, early;
      logic [30:0] dt;
      logic chk;
      logic signed [31:0] want;
   } sample_type;

   // Configuration shadow
   logic [30:0] sh_pb, sh_ti, sh_td, sh_ispan;
   logic signed [31:0] sh_ospan;
   logic [2:0] sh_alg;

   logic signed [31:0] increments_due[$];
   int mismatches = 0, received = 0, idle_cycles = 0;
   bit timed_out = 0;

   function automatic logic signed [63:0] clip(input logic signed [63:0] x);
      if (x > L_MAX) return L_MAX;
      if (x < L_MIN) return L_MIN;
      return x;
   endfunction

   function automatic logic signed [63:0] fmul(input logic signed [63:0] a, b);
      return clip((a * b) >>> 16);
   endfunction

   function automatic logic signed [63:0] fdiv(input logic signed [63:0] a, b);
      if (b == 0) return a > 0 ? L_MAX : (a < 0 ? L_MIN : 64'sd0);
      return clip((a * L_ONE) / b);
   endfunction

   // Expected increment for one sample under the shadowed configuration
   function automatic logic signed [31:0] pid_increment(input sample_type s);
      logic signed [63:0] dt, ispan, ks, ti, g, res, sum, e, v, rate, td;
      logic [2:0] alg;
      dt = s.dt == 0 ? 64'sd1 : 64'(s.dt);
      ispan = sh_ispan == 0 ? 64'sd1 : 64'(sh_ispan);
      td = 64'(sh_td);
      alg = sh_alg;
      res = 0;
      ks = fdiv(64'(sh_ospan), ispan);
      ti = sh_ti != 0 ? fmul(fdiv(dt, 64'(sh_ti)), 64'(s.err)) : fmul(dt, 64'(s.err));
      if (sh_pb == 0) res = fmul(ks, ti);
      else begin
         g = fmul(fdiv(100 * L_ONE, 64'(sh_pb)), ks);
         if (alg == ALG_AUTO || alg == ALG_AUTO_ALT) alg = s.cas ? ALG_PID : ALG_IPD;
         e = fmul(fdiv(td, dt), clip(64'(s.dpv) - 64'(s.dpv1)));
         case (alg)
            ALG_BASIC: begin
               rate = fdiv(clip(64'(s.derr) - 64'(s.derr1)), dt);
               if (rate < 3 * L_ONE && rate > -3 * L_ONE)
                  sum = clip(clip(64'(s.derr) + ti) + fmul(td, rate));
               else sum = clip(64'(s.dpv) + ti);
               res = fmul(g, sum);
            end
            ALG_IPD: begin
               sum = clip(64'(s.dpv) + ti);
               if (!s.early) sum = clip(sum + e);
               res = fmul(g, sum);
            end
            ALG_PID: begin
               res = fmul(g, clip(clip(64'(s.derr) + ti) + e));
               v = fdiv(64'(sh_ospan), 100 * L_ONE);
               if (res > 0 && res > v) res = v;
               else if (res < 0 && res < -v) res = -v;
            end
            default: res = 0;
         endcase
      end
      return res[31:0];
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_PROP_BAND:     sh_pb = val[30:0];
         CSR_INTEGRAL_TIME: sh_ti = val[30:0];
         CSR_DERIV_TIME:    sh_td = val[30:0];
         CSR_OUT_SPAN:      sh_ospan = val;
         CSR_IN_SPAN:       sh_ispan = val[30:0];
         CSR_ALGORITHM:     sh_alg = val[2:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Drain all outstanding responses and let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (increments_due.size() != 0 && !timed_out) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Valid stays up after acceptance only until the next call, in the same time step
   task automatic send(input sample_type s);
      logic signed [31:0] want;
      int n;
      want = pid_increment(s);
      if (s.chk && want !== s.want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees with predictor: row %0d predictor %0d",
                     s.want, want);
      end
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_error <= s.err;
      req_error_delta <= s.derr;
      req_prev_error_delta <= s.derr1;
      req_pv_delta <= s.dpv;
      req_prev_pv_delta <= s.dpv1;
      req_cascade_mode <= s.cas;
      req_early_step <= s.early;
      req_step_time <= s.dt;
      @(posedge clock);
      while (!req_ready && !timed_out) @(posedge clock);
      increments_due.push_back(want);
   endtask

   function automatic logic signed [31:0] rnd_q();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
         2: return $signed($urandom_range(0, 65535)) - 32768;
         default: return $urandom;
      endcase
   endfunction

   function automatic sample_type rnd_sample();
      sample_type s;
      s.err = rnd_q(); s.derr = rnd_q(); s.derr1 = rnd_q();
      s.dpv = rnd_q(); s.dpv1 = rnd_q();
      s.cas = 1'($urandom_range(0, 1)); s.early = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
         0: s.dt = $urandom_range(0, 1) ? 31'd0 : 31'h7fffffff;
         1: s.dt = 31'($urandom_range(1, 50)) << 16;
         2: s.dt = 31'($urandom_range(0, 4000));
         default: s.dt = 31'($urandom);
      endcase
      s.chk = 0; s.want = 0;
      return s;
   endfunction

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         received++;
         if (increments_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %0d", rsp_output_delta);
         end else begin
            automatic logic signed [31:0] w = increments_due.pop_front();
            if (rsp_output_delta !== w) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("output_delta mismatch: expected %0d actual %0d",
                           w, rsp_output_delta);
            end
         end
      end
   end

   // Response-side stalls
   initial begin : rsp_stall
      int n;
      @(negedge reset);
      forever begin
         rsp_ready <= 1'b1;
         @(posedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WD_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      sample_type tbl[$];
      int phase;
      sh_pb = 31'd6553600; sh_ti = 31'd655360; sh_td = 0;
      sh_ospan = 32'sd6553600; sh_ispan = 31'd6553600; sh_alg = ALG_AUTO;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at reset defaults: zero error gives zero, saturation at extremes
      tbl.push_back('{0, 0, 0, 0, 0, 0, 0, 31'h10000, 1, 0});
      tbl.push_back('{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                      32'h80000000, 1, 0, 31'h7fffffff, 0, 0});
      tbl.push_back('{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                      32'h7fffffff, 0, 1, 31'd0, 0, 0});
      tbl.push_back('{32'h10000, 32'h10000, 0, 32'h20000, 0, 0, 0, 31'h10000, 0, 0});
      tbl.push_back('{32'h10000, 32'h10000, 0, 32'h20000, 0, 1, 0, 31'h10000, 0, 0});
      tbl.push_back('{32'hffff0000, 32'h8000, 32'h4000, 32'h1000, 32'h3000, 1, 1,
                      31'h8000, 0, 0});
      foreach (tbl[i]) send(tbl[i]);
      wait_idle();

      // Walk every algorithm, the bypass, zero integral time and span extremes
      for (phase = 0; phase < 8; phase++) begin
         write_reg(CSR_ALGORITHM, 32'(phase));
         write_reg(CSR_DERIV_TIME, phase[0] ? 32'h7fffffff : 32'h20000);
         write_reg(CSR_PROP_BAND, phase == 6 ? 32'd0 : 32'h7fffffff >> phase);
         write_reg(CSR_INTEGRAL_TIME, phase == 3 ? 32'd0 : 32'h30000);
         write_reg(CSR_OUT_SPAN, phase == 4 ? 32'h80000000 : (phase == 5 ? 32'h7fffffff
                                                                           : 32'h640000));
         write_reg(CSR_IN_SPAN, phase == 2 ? 32'd0 : (phase == 7 ? 32'h7fffffff
                                                                 : 32'h640000));
         for (int k = 0; k < 3; k++) send(rnd_sample());
         wait_idle();
      end

      // Random part in phases of random configuration
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 200 == 0) begin
            wait_idle();
            write_reg(CSR_ALGORITHM, $urandom_range(0, 7));
            write_reg(CSR_PROP_BAND, $urandom_range(0, 7) == 0 ? 0 :
                                     $urandom_range(1 << 16, 400 << 16));
            write_reg(CSR_INTEGRAL_TIME, $urandom_range(0, 7) == 0 ? 0 : $urandom);
            write_reg(CSR_DERIV_TIME, $urandom_range(0, 1) ? $urandom_range(0, 20 << 16)
                                                           : $urandom);
            write_reg(CSR_OUT_SPAN, $urandom_range(0, 1) ? $urandom : $urandom_range(0,
                                                                        1000 << 16));
            write_reg(CSR_IN_SPAN, $urandom_range(1, 1000 << 16));
         end
         send(rnd_sample());
      end

      wait_idle();
      $display("Covered %0d responses over all algorithm codes, bypass and span extremes.",
               received);
      if (mismatches == 0 && increments_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
